[src/les_pkg.sv]
// Shared types and constants for the lane edge steering block.
// No dependencies; imported by every module under src.
package les_pkg;

  localparam int GAP_DEFAULT       = 15;
  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int WIDTH_RESET       = 640;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int VAL_W = 8;

  localparam logic CMD_STEER = 1'b0;
  localparam logic CMD_STOP  = 1'b1;

  localparam logic signed [VAL_W-1:0] VAL_MIN = -8'sd128;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 8'sd127;

  // Pixel request held in the input register
  typedef struct packed {
    logic valid;
    logic zero;
    logic last;
  } pix_req_t;

  // Frame end event towards the result register
  typedef struct packed {
    logic fire;
    logic locked;
  } frame_end_t;

endpackage

[src/les_in_stage.sv]
// Input register for pixel requests, with stall back to the source.
// Depends on les_pkg.
module les_in_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [les_pkg::PIX_W-1:0] pixel,
  input  logic                     last_in_frame,
  input  logic                     advance,
  output les_pkg::pix_req_t        req
);
  import les_pkg::*;

  assign in_stall = req.valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req.valid <= 1'b1;
    end else if (advance) begin
      req.valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      req.zero <= (pixel == '0);
      req.last <= last_in_frame;
    end
  end

endmodule

[src/les_track.sv]
// Zero history, column counter and lane edge tracking for one frame.
// Holds the frame width register. Depends on les_pkg.
module les_track #(
  parameter int GAP       = les_pkg::GAP_DEFAULT,
  parameter int MAX_WIDTH = les_pkg::MAX_WIDTH_DEFAULT,
  localparam int CW       = $clog2(MAX_WIDTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     frame_width_we,
  input  logic [les_pkg::CFG_W-1:0] frame_width,
  input  les_pkg::pix_req_t        req,
  input  logic                     advance,
  output les_pkg::frame_end_t      frame_end,
  output logic [CW-1:0]            left_out,
  output logic [CW-1:0]            right_out,
  output logic [CW-1:0]            width_out
);
  import les_pkg::*;

  localparam int EW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [CW-1:0] TWO_GAP = CW'(2 * GAP);
  localparam logic [CW-1:0] WIDTH_RST =
    CW'((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET);
  localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);

  logic [2*GAP-1:0] hist;
  logic [2*GAP:0]   hist_shift;
  logic [CW-1:0]    col, col_next;
  logic [CW:0]      col_inc;
  logic [CW-1:0]    width, width_eff;
  logic [EW-1:0]    cfg_ext;
  logic [CW-1:0]    left_edge, left_next;
  logic [CW-1:0]    right_edge, right_next;
  logic             row_has_triple, rht_seen, rht_next;
  logic             frame_locked, locked_next;
  logic             trip, row_end;

  always_comb begin
    cfg_ext = EW'(frame_width);
    if (cfg_ext == '0) begin
      width_eff = CW'(1);
    end else if (cfg_ext > MAX_W_E) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = cfg_ext[CW-1:0];
    end
  end

  always_comb begin
    hist_shift = {hist, req.zero};
    col_inc    = {1'b0, col} + {{CW{1'b0}}, 1'b1};
    trip = !frame_locked && (col >= TWO_GAP) && (col < width) &&
           hist_shift[0] && hist_shift[GAP] && hist_shift[2*GAP];
    left_next  = left_edge;
    right_next = right_edge;
    rht_seen   = row_has_triple;
    if (trip) begin
      if (!row_has_triple) begin
        left_next = col - TWO_GAP;
      end
      right_next = col;
      rht_seen   = 1'b1;
    end
    row_end     = (col_inc >= {1'b0, width}) || req.last;
    locked_next = frame_locked || (row_end && rht_seen);
    rht_next    = row_end ? 1'b0 : rht_seen;
    col_next    = row_end ? '0 : col_inc[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width          <= WIDTH_RST;
      hist           <= '0;
      col            <= '0;
      row_has_triple <= 1'b0;
      left_edge      <= '0;
      right_edge     <= '0;
      frame_locked   <= 1'b0;
    end else begin
      if (frame_width_we) begin
        width <= width_eff;
      end
      if (advance) begin
        if (req.last) begin
          hist           <= '0;
          col            <= '0;
          row_has_triple <= 1'b0;
          left_edge      <= '0;
          right_edge     <= '0;
          frame_locked   <= 1'b0;
        end else begin
          hist           <= hist_shift[2*GAP-1:0];
          col            <= col_next;
          row_has_triple <= rht_next;
          left_edge      <= left_next;
          right_edge     <= right_next;
          frame_locked   <= locked_next;
        end
      end
    end
  end

  assign frame_end.fire   = advance && req.last;
  assign frame_end.locked = locked_next;
  assign left_out         = left_next;
  assign right_out        = right_next;
  assign width_out        = width;

`ifndef NO_ASSERTIONS
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col} < (CW+1)'(MAX_WIDTH))
    else $error("column counter beyond maximum width");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    frame_end.fire |=> (col == '0) && !frame_locked && !row_has_triple)
    else $error("state not cleared after frame end");

  a_edge_order: assert property (@(posedge clk) disable iff (rst)
    frame_locked |-> {1'b0, right_edge} >= ({1'b0, left_edge} + {1'b0, TWO_GAP}))
    else $error("locked edges out of order");
`endif

endmodule

[src/les_steer.sv]
// Steering offset arithmetic and the result register.
// Depends on les_pkg.
module les_steer #(
  parameter int MAX_WIDTH = les_pkg::MAX_WIDTH_DEFAULT,
  localparam int CW       = $clog2(MAX_WIDTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  les_pkg::frame_end_t             frame_end,
  input  logic [CW-1:0]                   left_edge,
  input  logic [CW-1:0]                   right_edge,
  input  logic [CW-1:0]                   width,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic                            command_kind,
  output logic signed [les_pkg::VAL_W-1:0] command_value,
  output logic                            slot_free
);
  import les_pkg::*;

  localparam int SW = CW + 2;

  logic signed [SW-1:0]    sum, half;
  logic signed [VAL_W-1:0] sat;

  always_comb begin
    sum  = $signed({2'b00, left_edge}) + $signed({2'b00, right_edge})
         - $signed({2'b00, width});
    // truncate toward zero
    half = (sum + $signed({{(SW-1){1'b0}}, sum[SW-1] & sum[0]})) >>> 1;
    if (half < SW'(VAL_MIN)) begin
      sat = VAL_MIN;
    end else if (half > SW'(VAL_MAX)) begin
      sat = VAL_MAX;
    end else begin
      sat = half[VAL_W-1:0];
    end
  end

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_end.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (frame_end.fire) begin
      command_kind  <= frame_end.locked ? CMD_STEER : CMD_STOP;
      command_value <= frame_end.locked ? sat : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command_kind == CMD_STOP) |-> command_value == '0)
    else $error("stop request with non-zero value");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    frame_end.fire |-> slot_free)
    else $error("result register overwritten while held");
`endif

endmodule

[src/lane_edge_steering.sv]
// Lane edge steering, top level.
// Instantiates les_in_stage, les_track and les_steer; depends on les_pkg.
//
// Takes one mono8 pixel per clock in raster order while in_stall is low and,
// on the pixel marked last_in_frame, returns one request: a steering offset
// from the first row holding a dark triple, or a stop with value 0. The last
// pixel is registered in the input register, then the result in the result
// register. Input stall rises only when a frame-end pixel sits in the input
// register while the result register still holds an untaken request.
// frame_width may be written only with no pixel in flight.
module lane_edge_steering #(
  parameter int GAP       = les_pkg::GAP_DEFAULT,
  parameter int MAX_WIDTH = les_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            frame_width_we,
  input  logic [les_pkg::CFG_W-1:0]        frame_width,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [les_pkg::PIX_W-1:0]        pixel,
  input  logic                            last_in_frame,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            command_kind,
  output logic signed [les_pkg::VAL_W-1:0] command_value
);
  import les_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);

  pix_req_t   req;
  frame_end_t frame_end;
  logic       advance, slot_free;
  logic [CW-1:0] left_edge, right_edge, width;

  assign advance = req.valid && (!req.last || slot_free);

  les_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel         (pixel),
    .last_in_frame (last_in_frame),
    .advance       (advance),
    .req           (req)
  );

  les_track #(
    .GAP       (GAP),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .frame_width_we (frame_width_we),
    .frame_width    (frame_width),
    .req            (req),
    .advance        (advance),
    .frame_end      (frame_end),
    .left_out       (left_edge),
    .right_out      (right_edge),
    .width_out      (width)
  );

  les_steer #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_steer (
    .clk           (clk),
    .rst           (rst),
    .frame_end     (frame_end),
    .left_edge     (left_edge),
    .right_edge    (right_edge),
    .width         (width),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .command_kind  (command_kind),
    .command_value (command_value),
    .slot_free     (slot_free)
  );

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req.valid && req.last && out_valid && out_stall)
    else $error("input stalled without a held frame-end request");
`endif

endmodule

[dv/lane_edge_steering_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for lane_edge_steering: streams raster frames, predicts each
// steering or stop request and checks it field by field. Depends on les_pkg and the RTL.
module lane_edge_steering_tb;
  import les_pkg::*;

  localparam int GAP         = GAP_DEFAULT;
  localparam int HIST_LEN    = 2 * GAP + 1;
  localparam int LIMIT       = 400000;
  localparam int KEEP_WIDTH  = -1;
  localparam int NO_TRIPLE   = -1;
  localparam int FILL_NOISE  = -1;
  localparam int FILL_BRIGHT = -2;

  typedef struct packed {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
  } steer_cmd_t;

  typedef struct {
    int   width;
    int   npix;
    bit   last;
    int   k;
    int   k2;
    int   row;
    int   fill;
    bit   typed;
    logic kind;
    int   value;
  } frame_spec_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    frame_width_we;
  logic [CFG_W-1:0]        frame_width;
  logic                    in_valid;
  logic                    in_stall;
  logic [PIX_W-1:0]        pixel;
  logic                    last_in_frame;
  logic                    out_valid;
  logic                    out_stall;
  logic                    command_kind;
  logic signed [VAL_W-1:0] command_value;

  // predictor state
  logic [HIST_LEN-1:0] zero_hist;
  int                  col_pos, left_col, right_col;
  bit                  row_hit, locked;
  int                  width_reg;

  steer_cmd_t pending_cmds[$];
  bit         typed_on;
  steer_cmd_t typed_cmd;

  int cycle_count, pixels_taken, mismatches, cmds_checked, steers_seen, stops_seen;
  int input_held, frames_run, send_idle_pct, recv_stall_pct, hold_cycles;
  int rand_pixels, rand_results, rand_frames;
  bit mid_row_pending;

  // extremes, each special case, then a few rows left to the predictor
  frame_spec_t dir_frames [16] = '{
    '{KEEP_WIDTH, 1,    1, NO_TRIPLE, NO_TRIPLE, 0, 0,           1, CMD_STOP,  0},
    '{KEEP_WIDTH, 31,   1, 0,         NO_TRIPLE, 0, 255,         1, CMD_STEER, -128},
    '{286,        286,  1, 255,       NO_TRIPLE, 0, 1,           1, CMD_STEER, 127},
    '{0,          5,    1, NO_TRIPLE, NO_TRIPLE, 0, 0,           1, CMD_STOP,  0},
    '{2047,       61,   1, 30,        NO_TRIPLE, 0, 255,         1, CMD_STEER, -128},
    '{30,         40,   1, NO_TRIPLE, NO_TRIPLE, 0, 0,           1, CMD_STOP,  0},
    '{35,         35,   1, 0,         NO_TRIPLE, 0, 200,         1, CMD_STEER, -2},
    '{100,        50,   1, 5,         NO_TRIPLE, 0, 128,         1, CMD_STEER, -30},
    '{40,         75,   1, 2,         NO_TRIPLE, 1, 254,         1, CMD_STEER, -3},
    '{64,         64,   1, 3,         20,        0, 127,         1, CMD_STEER, -5},
    '{32,         32,   1, NO_TRIPLE, NO_TRIPLE, 0, 0,           1, CMD_STEER, 0},
    '{1,          3,    1, NO_TRIPLE, NO_TRIPLE, 0, 255,         1, CMD_STOP,  0},
    '{64,         40,   0, NO_TRIPLE, NO_TRIPLE, 0, 9,           0, CMD_STOP,  0},
    '{40,         80,   1, 4,         NO_TRIPLE, 1, FILL_BRIGHT, 0, CMD_STOP,  0},
    '{31,         31,   1, NO_TRIPLE, NO_TRIPLE, 0, 0,           1, CMD_STEER, 0},
    '{200,        60,   1, NO_TRIPLE, NO_TRIPLE, 0, FILL_NOISE,  0, CMD_STOP,  0}
  };

  lane_edge_steering dut (
    .clk            (clk),
    .rst            (rst),
    .frame_width_we (frame_width_we),
    .frame_width    (frame_width),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel          (pixel),
    .last_in_frame  (last_in_frame),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .command_kind   (command_kind),
    .command_value  (command_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int eff_width(int w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
    return w;
  endfunction

  function automatic bit on_triple(int k, int col);
    return k >= 0 && (col == k || col == k + GAP || col == k + 2 * GAP);
  endfunction

  task automatic clear_frame_state();
    zero_hist = '0;
    col_pos   = 0;
    row_hit   = 1'b0;
    left_col  = 0;
    right_col = 0;
    locked    = 1'b0;
  endtask

  // one accepted pixel through the edge search; queues the request on a frame end
  task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic last);
    int         w;
    int         col;
    int         offset;
    steer_cmd_t cmd;
    w   = eff_width(width_reg);
    col = col_pos;
    zero_hist = {zero_hist[HIST_LEN-2:0], pix == '0};
    if (!locked && col >= 2 * GAP && col < w &&
        zero_hist[0] && zero_hist[GAP] && zero_hist[2 * GAP]) begin
      if (!row_hit) left_col = col - 2 * GAP;
      right_col = col;
      row_hit   = 1'b1;
    end
    if (col + 1 >= w || last) begin
      if (row_hit) locked = 1'b1;
      row_hit = 1'b0;
      col_pos = 0;
    end else begin
      col_pos = col + 1;
    end
    if (last) begin
      if (locked) begin
        offset = (left_col + right_col - w) / 2;
        if (offset < int'(VAL_MIN)) offset = int'(VAL_MIN);
        if (offset > int'(VAL_MAX)) offset = int'(VAL_MAX);
        cmd.kind  = CMD_STEER;
        cmd.value = offset[VAL_W-1:0];
      end else begin
        cmd.kind  = CMD_STOP;
        cmd.value = '0;
      end
      if (typed_on) cmd = typed_cmd;
      pending_cmds.push_back(cmd);
      clear_frame_state();
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && in_stall) input_held++;
      if (in_valid && !in_stall) begin
        pixels_taken++;
        predict_pixel(pixel, last_in_frame);
      end
      if (out_valid && !out_stall) begin
        if (pending_cmds.size() == 0) begin
          $display("%0t: unexpected request kind %0b value %0d", $time,
                   command_kind, command_value);
          mismatches++;
        end else begin
          if (command_kind !== pending_cmds[0].kind) begin
            $display("%0t: command_kind expected %0b actual %0b", $time,
                     pending_cmds[0].kind, command_kind);
            mismatches++;
          end
          if (command_value !== pending_cmds[0].value) begin
            $display("%0t: command_value expected %0d actual %0d", $time,
                     pending_cmds[0].value, command_value);
            mismatches++;
          end
          void'(pending_cmds.pop_front());
        end
        cmds_checked++;
        if (command_kind == CMD_STOP) stops_seen++;
        else steers_seen++;
      end
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) @(negedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
    int seen;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    pixel         <= pix;
    last_in_frame <= last;
    seen = pixels_taken;
    while (pixels_taken == seen) @(negedge clk);
  endtask

  // no pixel in flight, every request back, then the pipeline latency
  task automatic drain_block();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_frame_width(input int w);
    drain_block();
    frame_width_we <= 1'b1;
    frame_width    <= w[CFG_W-1:0];
    @(negedge clk);
    frame_width_we <= 1'b0;
    width_reg = w & 32'h7FF;
  endtask

  task automatic run_frame(input frame_spec_t f);
    int               w;
    int               p;
    int               col;
    int               rw;
    logic [PIX_W-1:0] pix;
    if (f.width != KEEP_WIDTH) set_frame_width(f.width);
    typed_on        = f.typed;
    typed_cmd.kind  = f.kind;
    typed_cmd.value = f.value[VAL_W-1:0];
    w = eff_width(width_reg);
    for (p = 0; p < f.npix; p++) begin
      col = p % w;
      rw  = p / w;
      if (rw == f.row && (on_triple(f.k, col) || on_triple(f.k2, col))) pix = '0;
      else if (f.fill == FILL_NOISE)
        pix = ($urandom_range(2) == 0) ? '0 : PIX_W'($urandom_range(255));
      else if (f.fill == FILL_BRIGHT) pix = PIX_W'($urandom_range(255, 1));
      else pix = f.fill[PIX_W-1:0];
      send_pixel(pix, f.last && p == f.npix - 1);
    end
    frames_run++;
  endtask

  function automatic int pick_width();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(80, 31);
    if (r < 77) return $urandom_range(30, 1);
    if (r < 82) return 0;
    if (r < 92) return $urandom_range(200, 81);
    if (r < 96) return MAX_WIDTH_DEFAULT;
    if (r < 98) return 2047;
    return $urandom_range(2046, MAX_WIDTH_DEFAULT + 1);
  endfunction

  // mostly frames with planted triples on a bright background, some pure noise
  task automatic random_frame();
    frame_spec_t f;
    int          w;
    f.width = KEEP_WIDTH;
    if (mid_row_pending || $urandom_range(99) < 40) f.width = pick_width();
    w = eff_width(f.width == KEEP_WIDTH ? width_reg : f.width);
    if (w >= 512) f.npix = $urandom_range(160, 1);
    else f.npix = $urandom_range(w + w / 2, 1);
    f.last = ($urandom_range(99) >= 8);
    mid_row_pending = !f.last;
    f.fill = ($urandom_range(99) < 20) ? FILL_NOISE : FILL_BRIGHT;
    f.k    = NO_TRIPLE;
    f.k2   = NO_TRIPLE;
    if (w > 2 * GAP && $urandom_range(99) < 85) f.k = $urandom_range(w - 1 - 2 * GAP);
    if (w > 2 * GAP && $urandom_range(99) < 40) f.k2 = $urandom_range(w - 1 - 2 * GAP);
    f.row   = $urandom_range(f.npix / w);
    f.typed = 1'b0;
    f.kind  = CMD_STOP;
    f.value = 0;
    p_start: begin
      int before_px;
      before_px = pixels_taken;
      run_frame(f);
      rand_pixels += pixels_taken - before_px;
    end
    if (f.last) rand_results++;
  endtask

  // long output hold-off while one-pixel frames keep coming: input must back up
  task automatic backpressure_burst();
    frame_spec_t f;
    int          saved_idle;
    set_frame_width(1);
    @(posedge clk);
    hold_cycles = 300;
    @(negedge clk);
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    f = '{KEEP_WIDTH, 1, 1, NO_TRIPLE, NO_TRIPLE, 0, FILL_NOISE, 0, CMD_STOP, 0};
    repeat (12) run_frame(f);
    send_idle_pct = saved_idle;
    drain_block();
  endtask

  initial begin : main
    int i;
    rst            = 1'b1;
    frame_width_we = 1'b0;
    frame_width    = '0;
    in_valid       = 1'b0;
    pixel          = '0;
    last_in_frame  = 1'b0;
    out_stall      = 1'b0;
    cycle_count    = 0;
    pixels_taken   = 0;
    mismatches     = 0;
    cmds_checked   = 0;
    steers_seen    = 0;
    stops_seen     = 0;
    input_held     = 0;
    frames_run     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    rand_pixels    = 0;
    rand_results   = 0;
    rand_frames    = 0;
    mid_row_pending = 1'b0;
    typed_on       = 1'b0;
    typed_cmd      = '0;
    width_reg      = WIDTH_RESET;
    clear_frame_state();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < $size(dir_frames); i++) run_frame(dir_frames[i]);
    typed_on = 1'b0;

    backpressure_burst();
    mid_row_pending = 1'b1;

    while (rand_frames < 8) begin
      case (rand_frames % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      random_frame();
      rand_frames++;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Ran %0d frames, %0d pixels; %0d requests checked (%0d steer, %0d stop).",
             frames_run, pixels_taken, cmds_checked, steers_seen, stops_seen);
    $display("Random part %0d pixels, %0d frame ends; input held off %0d cycles.",
             rand_pixels, rand_results, input_held);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/les_pkg.sv
src/les_in_stage.sv
src/les_track.sv
src/les_steer.sv
src/lane_edge_steering.sv
dv/lane_edge_steering_tb.sv
